/* hdl/imuaf_pkg.sv */
// ----------------------------------------------------------------------------
// IMU attitude filter package
// Shared widths, register indexes, coefficient bundle and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package imuaf_pkg;

    localparam int RAW_W   = 16;   // raw sensor count
    localparam int ANGLE_W = 24;   // filtered angle
    localparam int STEP_W  = 16;   // step counter
    localparam int XY_W    = 36;   // CORDIC vector components
    localparam int Z_W     = 28;   // CORDIC angle, 2^-16 degree
    localparam int ACC_W   = 68;   // filter accumulator
    localparam int ADDR_W  = 4;    // APB byte address

    localparam logic [1:0] REG_BLEND  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_ENABLE = 2'd3;

    typedef struct packed {
        logic [15:0] blend_coeff;
        logic [23:0] sample_period;
    } t_coef;

    // atan(2^-i) in units of 2^-16 degree, rounded.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 28'sd2949120;
            5'd1:    v = 28'sd1740967;
            5'd2:    v = 28'sd919879;
            5'd3:    v = 28'sd466945;
            5'd4:    v = 28'sd234379;
            5'd5:    v = 28'sd117304;
            5'd6:    v = 28'sd58666;
            5'd7:    v = 28'sd29335;
            5'd8:    v = 28'sd14668;
            5'd9:    v = 28'sd7334;
            5'd10:   v = 28'sd3667;
            5'd11:   v = 28'sd1833;
            5'd12:   v = 28'sd917;
            5'd13:   v = 28'sd458;
            5'd14:   v = 28'sd229;
            5'd15:   v = 28'sd115;
            5'd16:   v = 28'sd57;
            5'd17:   v = 28'sd29;
            5'd18:   v = 28'sd14;
            5'd19:   v = 28'sd7;
            5'd20:   v = 28'sd4;
            5'd21:   v = 28'sd2;
            5'd22:   v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/imuaf_if.sv */
// ----------------------------------------------------------------------------
// IMU attitude filter channels
// Valid/ready channels for raw samples and for filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface imuaf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               clear_steps;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    clear_steps, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    clear_steps, output ready);
endinterface

interface imuaf_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] roll_angle;
    logic signed [23:0] pitch_angle;
    logic signed [23:0] yaw_angle;
    logic        [15:0] step_count;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, step_count,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, step_count,
                    output ready);
endinterface

`default_nettype wire

/* hdl/imuaf_cordic.sv */
// ----------------------------------------------------------------------------
// IMU attitude filter CORDIC
// Iterative vectoring atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imuaf_cordic #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [16:0]            i_y,
    input  wire logic signed [16:0]            i_x,
    output logic                               o_done,
    output logic signed [imuaf_pkg::Z_W-1:0]   o_z
);
    import imuaf_pkg::*;

    localparam int CW = $clog2(CORDIC_ITERATIONS);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_i;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic                   r_zero;

    logic                   w_neg;
    logic signed [16:0]     w_x0;
    logic signed [16:0]     w_y0;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;

    assign w_neg = i_x[16];
    assign w_x0  = w_neg ? -i_x : i_x;
    assign w_y0  = w_neg ? -i_y : i_y;
    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                r_x    <= $signed({{(XY_W-33){w_x0[16]}}, w_x0, 16'd0});
                r_y    <= $signed({{(XY_W-33){w_y0[16]}}, w_y0, 16'd0});
                if (!w_neg) begin
                    r_z <= '0;
                end else if (!i_y[16]) begin
                    r_z <= Z_W'(180 * 65536);
                end else begin
                    r_z <= -Z_W'(180 * 65536);
                end
            end else if (r_busy) begin
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + atan_entry(5'(r_i));
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - atan_entry(5'(r_i));
                end
                r_i <= r_i + 1'b1;
                if (r_i == CW'(CORDIC_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_zero ? '0 : r_z;

endmodule

`default_nettype wire

/* hdl/imuaf_mac.sv */
// ----------------------------------------------------------------------------
// IMU attitude filter lane
// Bit-serial multiply-accumulate for one complementary filter axis.
// ----------------------------------------------------------------------------
`default_nettype none

module imuaf_mac #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire imuaf_pkg::t_coef                 i_coef,
    input  wire logic signed [23:0]               i_est,
    input  wire logic signed [15:0]               i_gyro,
    input  wire logic signed [imuaf_pkg::Z_W-1:0] i_tilt,
    output logic                                  o_done,
    output logic signed [23:0]                    o_est
);
    import imuaf_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_GYRO = 2'd1;
    localparam logic [1:0] PH_GAIN = 2'd2;
    localparam logic [1:0] PH_TILT = 2'd3;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (39 - ANGLE_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] AMAX = {{(ACC_W-23){1'b0}}, {23{1'b1}}};
    localparam logic signed [ACC_W-1:0] AMIN = {{(ACC_W-23){1'b1}}, 23'd0};

    logic [1:0]              r_ph;
    logic [4:0]              r_cnt;
    logic signed [ACC_W-1:0] r_a;
    logic [23:0]             r_b;
    logic signed [ACC_W-1:0] r_p;
    logic signed [23:0]      r_est;
    logic                    r_done;

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_estsh;
    logic signed [ACC_W-1:0] w_shr;
    logic signed [23:0]      w_sat;

    assign w_sum   = r_p + (r_b[0] ? r_a : '0);
    assign w_estsh = $signed({{(ACC_W-24){i_est[23]}}, i_est}) <<< (24 - ANGLE_FRAC_BITS);
    assign w_shr   = (w_sum + RND) >>> (40 - ANGLE_FRAC_BITS);

    always_comb begin
        if (w_shr > AMAX) begin
            w_sat = 24'sh7FFFFF;
        end else if (w_shr < AMIN) begin
            w_sat = 24'sh800000;
        end else begin
            w_sat = w_shr[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_a   <= $signed({{(ACC_W-16){i_gyro[15]}}, i_gyro});
                        r_b   <= i_coef.sample_period;
                        r_p   <= '0;
                        r_cnt <= 5'd23;
                        r_ph  <= PH_GYRO;
                    end
                end
                PH_GYRO: begin
                    r_p   <= w_sum;
                    r_a   <= r_a <<< 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        // Estimate plus gyro integral, in 2^-24 degree, becomes the gyro-side multiplicand.
                        r_a   <= w_sum + w_estsh;
                        r_b   <= {8'd0, i_coef.blend_coeff};
                        r_p   <= '0;
                        r_cnt <= 5'd15;
                        r_ph  <= PH_GAIN;
                    end
                end
                PH_GAIN: begin
                    r_p   <= w_sum;
                    r_a   <= r_a <<< 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_a   <= $signed({{(ACC_W-Z_W){i_tilt[Z_W-1]}}, i_tilt}) <<< 8;
                        r_b   <= {7'd0, 17'h10000 - {1'b0, i_coef.blend_coeff}};
                        r_cnt <= 5'd16;
                        r_ph  <= PH_TILT;
                    end
                end
                PH_TILT: begin
                    r_p   <= w_sum;
                    r_a   <= r_a <<< 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_est  <= w_sat;
                        r_done <= 1'b1;
                        r_ph   <= PH_IDLE;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_est  = r_est;

endmodule

`default_nettype wire

/* hdl/imu_attitude_filter_step_counter.sv */
// ----------------------------------------------------------------------------
// IMU attitude filter with step counter
// Complementary roll/pitch/yaw filters and a yaw-swing step counter.
// ----------------------------------------------------------------------------
// Each sample transaction carries one raw six-axis reading. The block first
// runs a shared iterative CORDIC twice, once for the roll tilt angle
// atan2(accel_y, accel_z) and once for the pitch tilt angle
// atan2(-accel_x, accel_z), one micro-rotation per clock. Then three
// bit-serial filter lanes work in parallel, one multiplier bit per clock:
// first gyro times sample_period, then the gyro weight and last the
// accelerometer weight. A new sample is taken only when the previous one
// has left the work stages; the finished result sits in an output register,
// so one result may wait for its consumer while the next sample is already
// in work. A result that is still waiting when the next one is finished
// holds that one back until it is taken. Configuration registers are written
// through the APB port; the user must write them only while the block is
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_attitude_filter_step_counter #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    imuaf_in_if.sink                            i_smp,
    imuaf_out_if.source                         o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [imuaf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import imuaf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROLL  = 3'd1;
    localparam logic [2:0] S_PITCH = 3'd2;
    localparam logic [2:0] S_FILT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Configuration registers.
    logic [15:0] r_blend;
    logic [23:0] r_period;
    logic [15:0] r_thresh;
    logic        r_enable;

    // Sequencer and captured sample.
    logic [2:0]             r_state;
    logic                   r_cstart;
    logic                   r_mstart;
    logic signed [15:0]     r_ax;
    logic signed [15:0]     r_ay;
    logic signed [15:0]     r_az;
    logic signed [15:0]     r_gx;
    logic signed [15:0]     r_gy;
    logic signed [15:0]     r_gz;
    logic signed [Z_W-1:0]  r_tilt_roll;
    logic signed [Z_W-1:0]  r_tilt_pitch;

    // Filter and step state.
    logic signed [23:0]     r_roll;
    logic signed [23:0]     r_pitch;
    logic signed [23:0]     r_yaw;
    logic                   r_left;
    logic                   r_right;
    logic                   r_half;
    logic [STEP_W-1:0]      r_steps;

    // Output register.
    logic                   r_out_valid;
    logic signed [23:0]     r_out_roll;
    logic signed [23:0]     r_out_pitch;
    logic signed [23:0]     r_out_yaw;
    logic [STEP_W-1:0]      r_out_steps;

    logic                   w_accept;
    logic                   w_cfg_wr;
    logic                   w_cdone;
    logic signed [Z_W-1:0]  w_cz;
    logic signed [16:0]     w_cy;
    logic signed [16:0]     w_cx;
    t_coef                  w_coef;
    logic                   w_done_r;
    logic                   w_done_p;
    logic                   w_done_y;
    logic signed [23:0]     w_roll;
    logic signed [23:0]     w_pitch;
    logic signed [23:0]     w_yaw;
    logic                   w_commit;

    // Step logic on the new yaw estimate.
    logic                   w_above;
    logic                   w_below;
    logic                   n_left;
    logic                   n_right;
    logic                   n_half;
    logic [STEP_W-1:0]      n_steps;

    assign w_accept = i_smp.valid && i_smp.ready;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign pready = 1'b1;

    assign w_coef.blend_coeff   = r_blend;
    assign w_coef.sample_period = r_period;

    // The CORDIC sees the roll operands first and the pitch operands second.
    assign w_cx = {r_az[15], r_az};
    assign w_cy = (r_state == S_PITCH) ? -{r_ax[15], r_ax} : {r_ay[15], r_ay};

    always_comb begin
        case (paddr[3:2])
            REG_BLEND:  prdata = {16'd0, r_blend};
            REG_PERIOD: prdata = {8'd0, r_period};
            REG_THRESH: prdata = {16'd0, r_thresh};
            REG_ENABLE: prdata = {31'd0, r_enable};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend  <= 16'd58982;
            r_period <= 24'd83886;
            r_thresh <= 16'd5120;
            r_enable <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_BLEND:  r_blend  <= pwdata[15:0];
                REG_PERIOD: r_period <= pwdata[23:0];
                REG_THRESH: r_thresh <= pwdata[15:0];
                REG_ENABLE: r_enable <= pwdata[0];
                default:    ;
            endcase
        end
    end

    imuaf_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_y     (w_cy),
        .i_x     (w_cx),
        .o_done  (w_cdone),
        .o_z     (w_cz)
    );

    imuaf_mac #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_mac_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_coef(w_coef),
        .i_est(r_roll), .i_gyro(r_gx), .i_tilt(r_tilt_roll),
        .o_done(w_done_r), .o_est(w_roll)
    );

    imuaf_mac #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_mac_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_coef(w_coef),
        .i_est(r_pitch), .i_gyro(r_gy), .i_tilt(r_tilt_pitch),
        .o_done(w_done_p), .o_est(w_pitch)
    );

    // Yaw has no accelerometer reference, so its tilt term is zero.
    imuaf_mac #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_mac_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_coef(w_coef),
        .i_est(r_yaw), .i_gyro(r_gz), .i_tilt('0),
        .o_done(w_done_y), .o_est(w_yaw)
    );

    // A swing above the positive threshold and one below the negative
    // threshold must alternate; every second swing adds a step.
    assign w_above = $signed({w_yaw[23], w_yaw}) > $signed({9'd0, r_thresh});
    assign w_below = $signed({w_yaw[23], w_yaw}) < -$signed({9'd0, r_thresh});

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_half  = r_half;
        n_steps = r_steps;
        if (r_enable) begin
            if (w_above && !r_left) begin
                n_left  = 1'b1;
                n_right = 1'b0;
                n_steps = r_half ? r_steps + 1'b1 : r_steps;
                n_half  = !r_half;
            end
            if (w_below && !r_right) begin
                n_right = 1'b1;
                n_left  = 1'b0;
                n_steps = r_half ? r_steps + 1'b1 : r_steps;
                n_half  = !r_half;
            end
        end
    end

    // The result is committed once the output register is free.
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cstart    <= 1'b0;
            r_mstart    <= 1'b0;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_half      <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            r_mstart <= 1'b0;
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ax     <= i_smp.accel_x;
                        r_ay     <= i_smp.accel_y;
                        r_az     <= i_smp.accel_z;
                        r_gx     <= i_smp.gyro_x;
                        r_gy     <= i_smp.gyro_y;
                        r_gz     <= i_smp.gyro_z;
                        r_cstart <= 1'b1;
                        r_state  <= S_ROLL;
                        // A clear request acts before this sample is counted.
                        if (i_smp.clear_steps) begin
                            r_steps <= '0;
                            r_left  <= 1'b0;
                            r_right <= 1'b0;
                            r_half  <= 1'b0;
                        end
                    end
                end
                S_ROLL: begin
                    if (w_cdone) begin
                        r_tilt_roll <= w_cz;
                        r_cstart    <= 1'b1;
                        r_state     <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    if (w_cdone) begin
                        r_tilt_pitch <= w_cz;
                        r_mstart     <= 1'b1;
                        r_state      <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (w_done_r) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_roll      <= w_roll;
                        r_pitch     <= w_pitch;
                        r_yaw       <= w_yaw;
                        r_left      <= n_left;
                        r_right     <= n_right;
                        r_half      <= n_half;
                        r_steps     <= n_steps;
                        r_out_valid <= 1'b1;
                        r_out_roll  <= w_roll;
                        r_out_pitch <= w_pitch;
                        r_out_yaw   <= w_yaw;
                        r_out_steps <= n_steps;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.roll_angle  = r_out_roll;
    assign o_res.pitch_angle = r_out_pitch;
    assign o_res.yaw_angle   = r_out_yaw;
    assign o_res.step_count  = r_out_steps;

    // The CORDIC finishes only while the sequencer waits for a tilt angle.
    a_cordic_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == S_ROLL || r_state == S_PITCH))
        else $error("CORDIC finished outside a tilt state");

    // All three lanes start together and so finish together, in S_FILT.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_r |-> (w_done_p && w_done_y && r_state == S_FILT))
        else $error("filter lanes out of step");

    // An accepted sample always starts the roll tilt angle next.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_cstart && r_state == S_ROLL))
        else $error("accepted sample did not start the CORDIC");

endmodule

`default_nettype wire
